[src/ps2kd_pkg.sv]
package ps2kd_pkg;

  localparam logic [7:0] CodeAck       = 8'hFA;
  localparam logic [7:0] CodePrefix    = 8'hE0;
  localparam logic [6:0] CodeLshift    = 7'h2A;
  localparam logic [6:0] CodeLeft      = 7'h4B;
  localparam logic [6:0] CodeUp        = 7'h48;
  localparam logic [6:0] CodeRight     = 7'h4D;
  localparam logic [6:0] CodeDown      = 7'h50;
  localparam logic [6:0] CodeBackspace = 7'h0E;
  localparam logic [6:0] CodeEnter     = 7'h1C;

  typedef enum logic [2:0] {
    KIND_CHAR      = 3'd0,
    KIND_BACKSPACE = 3'd1,
    KIND_ENTER     = 3'd2,
    KIND_LEFT      = 3'd3,
    KIND_UP        = 3'd4,
    KIND_RIGHT     = 3'd5,
    KIND_DOWN      = 3'd6
  } key_kind_e;

  typedef struct packed {
    logic      hit;
    key_kind_e kind;
    logic [6:0] chr;
  } key_result_t;

endpackage

[src/ps2kd_decode.sv]
module ps2kd_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic [7:0]            scan_byte_i,
  output ps2kd_pkg::key_result_t res_o
);
  import ps2kd_pkg::*;

  function automatic logic [6:0] asc(input logic [7:0] c);
    return c[6:0];
  endfunction

  logic       shift_q, shift_d;
  logic       ext_q, ext_d;
  logic       release_w;
  logic [6:0] code_w;
  logic       lut_hit;
  logic [6:0] lut_char;
  logic [6:0] out_char;

  assign release_w = scan_byte_i[7];
  assign code_w    = scan_byte_i[6:0];

  // Key table for unprefixed presses: upper case letters, plain digits, ; , . and space.
  always_comb begin
    lut_hit  = 1'b1;
    lut_char = '0;
    case (code_w) inside
      [7'h02:7'h0A]: lut_char = code_w + 7'h2F;
      7'h0B: lut_char = asc("0");
      7'h10: lut_char = asc("Q");
      7'h11: lut_char = asc("W");
      7'h12: lut_char = asc("E");
      7'h13: lut_char = asc("R");
      7'h14: lut_char = asc("T");
      7'h15: lut_char = asc("Y");
      7'h16: lut_char = asc("U");
      7'h17: lut_char = asc("I");
      7'h18: lut_char = asc("O");
      7'h19: lut_char = asc("P");
      7'h1E: lut_char = asc("A");
      7'h1F: lut_char = asc("S");
      7'h20: lut_char = asc("D");
      7'h21: lut_char = asc("F");
      7'h22: lut_char = asc("G");
      7'h23: lut_char = asc("H");
      7'h24: lut_char = asc("J");
      7'h25: lut_char = asc("K");
      7'h26: lut_char = asc("L");
      7'h27: lut_char = asc(";");
      7'h2C: lut_char = asc("Z");
      7'h2D: lut_char = asc("X");
      7'h2E: lut_char = asc("C");
      7'h2F: lut_char = asc("V");
      7'h30: lut_char = asc("B");
      7'h31: lut_char = asc("N");
      7'h32: lut_char = asc("M");
      7'h33: lut_char = asc(",");
      7'h34: lut_char = asc(".");
      7'h39: lut_char = asc(" ");
      default: lut_hit = 1'b0;
    endcase
  end

  // Apply shift: lower-case letters when not held, digit symbols when held.
  always_comb begin
    out_char = lut_char;
    if (!shift_q && (lut_char inside {[asc("A"):asc("Z")]})) begin
      out_char = lut_char + 7'd32;
    end else if (shift_q) begin
      case (lut_char)
        asc("0"): out_char = asc(")");
        asc("1"): out_char = asc("!");
        asc("2"): out_char = asc("@");
        asc("3"): out_char = asc("#");
        asc("4"): out_char = asc("$");
        asc("5"): out_char = asc("%");
        asc("6"): out_char = asc("^");
        asc("7"): out_char = asc("&");
        asc("8"): out_char = asc("*");
        asc("9"): out_char = asc("(");
        default: out_char = lut_char;
      endcase
    end
  end

  always_comb begin
    shift_d    = shift_q;
    ext_d      = ext_q;
    res_o.hit  = 1'b0;
    res_o.kind = KIND_CHAR;
    res_o.chr  = '0;
    if (scan_byte_i == CodeAck) begin
      // drop acknowledge, keep flags
    end else if (scan_byte_i == CodePrefix) begin
      ext_d = 1'b1;
    end else begin
      ext_d = 1'b0;
      if (code_w == CodeLshift) begin
        shift_d = !release_w;
      end else if (!release_w) begin
        if (ext_q) begin
          case (code_w)
            CodeLeft: begin
              res_o.hit  = 1'b1;
              res_o.kind = KIND_LEFT;
            end
            CodeUp: begin
              res_o.hit  = 1'b1;
              res_o.kind = KIND_UP;
            end
            CodeRight: begin
              res_o.hit  = 1'b1;
              res_o.kind = KIND_RIGHT;
            end
            CodeDown: begin
              res_o.hit  = 1'b1;
              res_o.kind = KIND_DOWN;
            end
            default: res_o.hit = 1'b0;
          endcase
        end else if (code_w == CodeBackspace) begin
          res_o.hit  = 1'b1;
          res_o.kind = KIND_BACKSPACE;
        end else if (code_w == CodeEnter) begin
          res_o.hit  = 1'b1;
          res_o.kind = KIND_ENTER;
        end else begin
          res_o.hit = lut_hit;
          res_o.chr = lut_hit ? out_char : 7'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 1'b0;
      ext_q   <= 1'b0;
    end else if (advance_i) begin
      shift_q <= shift_d;
      ext_q   <= ext_d;
    end
  end

endmodule

[src/ps2_scan_code_to_key_decoder.sv]
// PS/2 scan-code set 1 key decoder.
//
// Input channel: one raw keyboard byte per request on scan_byte_i, qualified
// by in_valid_i and accepted at a clock edge where in_stall_o is low.
// Output channel: one decoded key per request on key_kind_o / key_char_o,
// qualified by out_valid_o and taken when out_stall_i is low. Bytes that
// decode to nothing (ACK, E0 prefix, shift, releases, unknown keys) leave no
// output request; all of them but ACK update the shift and prefix flags.
//
// Acceptance loads the byte into the input register; the table decode of that
// register then loads into the output register when that register is free.
// Throughput is one byte per cycle while the receiver does not stall, set by the
// single decode stage; the input register refills in the same cycle its byte
// moves on.
//
// Reset clears both valid flags, the shift flag and the pending prefix flag.
// While the receiver stalls a valid result, the result holds, the byte in
// the input register holds, and in_stall_o rises once that register is full.
module ps2_scan_code_to_key_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] scan_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] key_kind_o,
  output logic [6:0] key_char_o
);
  import ps2kd_pkg::*;

  logic        in_valid_q;
  logic [7:0]  byte_q;
  logic        out_valid_q;
  logic [2:0]  kind_q;
  logic [6:0]  char_q;
  logic        out_free;
  logic        advance;
  logic        in_take;
  key_result_t res;

  // The output register can load when empty or when its request leaves now.
  assign out_free   = !out_valid_q || !out_stall_i;
  // Advance the held byte through decode whenever the result slot is free.
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  ps2kd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .advance_i   (advance),
    .scan_byte_i (byte_q),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (out_free) begin
        out_valid_q <= advance && res.hit;
      end
    end
  end

  // Payload registers: byte on take, key on a decoded hit; hold otherwise.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      byte_q <= scan_byte_i;
    end
    if (advance && res.hit) begin
      kind_q <= res.kind;
      char_q <= res.chr;
    end
  end

  assign out_valid_o = out_valid_q;
  assign key_kind_o  = kind_q;
  assign key_char_o  = char_q;

endmodule

[tb/ps2kd_key_checker.sv]
`timescale 1ns / 100ps

// Watches both channels of the decoder, predicts each decoded key from the
// scan bytes taken in, and compares the keys handed out in order.
module ps2kd_key_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  logic [7:0] scan_byte_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  logic [2:0] key_kind_i,
  input  logic [6:0] key_char_i,
  output int         mismatches_o,
  output int         pending_keys_o,
  output int         keys_checked_o
);
  import ps2kd_pkg::*;

  // Rows of the set-1 layout, leftmost character at the lowest code.
  localparam logic [6:0] DigitRowFirst = 7'h02;
  localparam logic [6:0] DigitRowLast  = 7'h0B;
  localparam logic [6:0] QRowFirst     = 7'h10;
  localparam logic [6:0] QRowLast      = 7'h19;
  localparam logic [6:0] ARowFirst     = 7'h1E;
  localparam logic [6:0] ARowLast      = 7'h27;
  localparam logic [6:0] ZRowFirst     = 7'h2C;
  localparam logic [6:0] ZRowLast      = 7'h34;
  localparam logic [6:0] SpaceCode     = 7'h39;

  localparam logic [79:0] DigitRow   = "1234567890";
  localparam logic [79:0] QRow       = "QWERTYUIOP";
  localparam logic [79:0] ARow       = "ASDFGHJKL;";
  // Last slot is never reached: the bottom row ends at the period.
  localparam logic [79:0] ZRow       = "ZXCVBNM,.?";
  localparam logic [79:0] DigitShift = ")!@#$%^&*(";
  localparam logic [7:0]  CaseOffset = 8'd32;

  typedef struct {
    key_kind_e  kind;
    logic [6:0] chr;
  } decoded_key_t;

  decoded_key_t key_fifo[$];
  bit shift_on;
  bit prefix_armed;
  int mismatch_count;
  int pending_count;
  int checked_count;

  assign mismatches_o   = mismatch_count;
  assign pending_keys_o = pending_count;
  assign keys_checked_o = checked_count;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    checked_count  = 0;
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] key check: %s", $realtime, what);
    mismatch_count++;
  endtask

  function automatic logic [7:0] row_char(input logic [79:0] row, input int idx);
    return row[(9 - idx) * 8 +: 8];
  endfunction

  function automatic logic [7:0] key_label(input logic [6:0] code);
    if (code >= DigitRowFirst && code <= DigitRowLast)
      return row_char(DigitRow, int'(code - DigitRowFirst));
    if (code >= QRowFirst && code <= QRowLast)
      return row_char(QRow, int'(code - QRowFirst));
    if (code >= ARowFirst && code <= ARowLast)
      return row_char(ARow, int'(code - ARowFirst));
    if (code >= ZRowFirst && code <= ZRowLast)
      return row_char(ZRow, int'(code - ZRowFirst));
    if (code == SpaceCode) return " ";
    return 8'd0;
  endfunction

  // Advance the shift and prefix flags by one byte; flag a key if one results.
  task automatic decode_scan_byte(input logic [7:0] b, output bit hit, output decoded_key_t k);
    logic [6:0] code;
    bit         was_armed;
    logic [7:0] ch;
    hit   = 1'b0;
    k.kind = KIND_CHAR;
    k.chr  = '0;
    if (b == CodeAck) return;
    if (b == CodePrefix) begin
      prefix_armed = 1'b1;
      return;
    end
    code         = b[6:0];
    was_armed    = prefix_armed;
    prefix_armed = 1'b0;
    if (code == CodeLshift) begin
      shift_on = !b[7];
      return;
    end
    if (b[7]) return;
    if (was_armed) begin
      case (code)
        CodeLeft:  k.kind = KIND_LEFT;
        CodeUp:    k.kind = KIND_UP;
        CodeRight: k.kind = KIND_RIGHT;
        CodeDown:  k.kind = KIND_DOWN;
        default:   return;
      endcase
    end else if (code == CodeBackspace) begin
      k.kind = KIND_BACKSPACE;
    end else if (code == CodeEnter) begin
      k.kind = KIND_ENTER;
    end else begin
      ch = key_label(code);
      if (ch == 8'd0) return;
      if (!shift_on && ch >= "A" && ch <= "Z") ch = ch + CaseOffset;
      else if (shift_on && ch >= "0" && ch <= "9") ch = row_char(DigitShift, int'(ch - "0"));
      k.chr = ch[6:0];
    end
    hit = 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    decoded_key_t want;
    decoded_key_t next_key;
    bit           hit;
    if (!rst_ni) begin
      shift_on     = 1'b0;
      prefix_armed = 1'b0;
      key_fifo.delete();
      pending_count = 0;
    end else begin
      // Drain first: a key leaving now can never come from the byte entering now.
      if (out_valid_i && !out_stall_i) begin
        if (key_fifo.size() == 0) begin
          report_mismatch($sformatf("unexpected key kind %0d char %h", key_kind_i, key_char_i));
        end else begin
          want = key_fifo.pop_front();
          checked_count++;
          if (key_kind_i !== 3'(want.kind))
            report_mismatch($sformatf("kind %0d, want %0d", key_kind_i, want.kind));
          if (key_char_i !== want.chr)
            report_mismatch($sformatf("char %h, want %h", key_char_i, want.chr));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        decode_scan_byte(scan_byte_i, hit, next_key);
        if (hit) key_fifo.insert(key_fifo.size(), next_key);
      end
      pending_count = key_fifo.size();
    end
  end

endmodule

[tb/ps2_scan_code_to_key_decoder_tb.sv]
`timescale 1ns / 100ps

module ps2_scan_code_to_key_decoder_tb;
  import ps2kd_pkg::*;

  // Scan bytes used by the opening directed run.
  localparam logic [7:0] KeyA         = 8'h1E;
  localparam logic [7:0] KeyNine      = 8'h0A;
  localparam logic [7:0] KeyZero      = 8'h0B;
  localparam logic [7:0] KeyQ         = 8'h10;
  localparam logic [7:0] KeySpace     = 8'h39;
  localparam logic [7:0] KeySemicolon = 8'h27;
  localparam logic [7:0] KeySlash     = 8'h35;
  // Random typing draws codes up to just past the space bar.
  localparam int         KeyTopTyped  = 'h3A;
  localparam int         ItemTarget   = 1350;
  localparam int         DrainCycles  = 10;
  localparam int         StallEpoch   = 150;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic [7:0] scan_byte_i = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [2:0] key_kind_o;
  logic [6:0] key_char_o;

  int mismatches;
  int pending_keys;
  int keys_checked;
  int bytes_sent = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_run  = 0;
  int stall_tick = 0;

  ps2_scan_code_to_key_decoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .scan_byte_i (scan_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .key_kind_o  (key_kind_o),
    .key_char_o  (key_char_o)
  );

  ps2kd_key_checker key_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .scan_byte_i    (scan_byte_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .key_kind_i     (key_kind_o),
    .key_char_i     (key_char_o),
    .mismatches_o   (mismatches),
    .pending_keys_o (pending_keys),
    .keys_checked_o (keys_checked)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop in case the handshake locks up.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // Receiver stall pattern: switch between free flow, random stalls,
  // long stall runs and a fixed one-in-three opening every epoch.
  always @(posedge clk_i) begin
    stall_tick++;
    if (stall_tick % StallEpoch == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 9) < 3);
      2: begin
        if (stall_run == 0 && $urandom_range(0, 5) == 0) stall_run = $urandom_range(1, 15);
        if (stall_run > 0) begin
          stall_run--;
          out_stall_i <= 1'b1;
        end else begin
          out_stall_i <= 1'b0;
        end
      end
      default: out_stall_i <= (stall_tick % 3 != 0);
    endcase
  end

  // Present one byte and hold it until the decoder takes it. Stall is read
  // at the falling edge, where everything launched at the rising edge has
  // settled, so the decision matches what the decoder sees at the next edge.
  task automatic send_byte(input logic [7:0] b);
    logic stalled;
    in_valid_i  <= 1'b1;
    scan_byte_i <= b;
    do begin
      @(negedge clk_i);
      stalled = in_stall_o;
      @(posedge clk_i);
    end while (stalled);
  endtask

  // Send in bursts: when a burst runs out, drop valid for a random gap and
  // draw the next burst length. Long bursts give stretches with no idling.
  task automatic put_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    send_byte(b);
    // ACKs are dropped by the decoder; leave them out of the item count.
    if (b != CodeAck) bytes_sent++;
  endtask

  // Press a key, and release it about half the time.
  task automatic press_key(input logic [6:0] code);
    put_byte({1'b0, code});
    if ($urandom_range(0, 1) == 1) put_byte({1'b1, code});
  endtask

  // Hold off the sender until every predicted key has come out.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_keys != 0);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    logic [7:0] opener[$];
    logic [6:0] arrow;
    int         pick;
    int         n;
    bit         paused;
    paused = 1'b0;
    // Walk table entries, the no-entry code, backspace and enter, shift on
    // digits and punctuation, repeated prefixes, an ACK inside a prefix,
    // prefixed non-arrows, a shift release and a key release that clear the
    // prefix, and the top byte.
    opener = '{KeyA, KeyZero, KeySpace, KeySemicolon, KeySlash,
               {1'b0, CodeBackspace}, {1'b0, CodeEnter}, CodeAck,
               {1'b0, CodeLshift}, KeyQ, KeyNine, KeyZero, KeySemicolon,
               CodePrefix, {1'b0, CodeLeft}, CodePrefix, CodePrefix, {1'b0, CodeUp},
               CodePrefix, CodeAck, {1'b0, CodeRight}, CodePrefix, {1'b0, CodeBackspace},
               CodePrefix, {1'b1, CodeLshift}, KeyA, CodePrefix, {1'b1, KeyA[6:0]},
               {1'b0, CodeDown}, 8'hFF};

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (opener[i]) put_byte(opener[i]);
    hold_until_drained();

    // Mostly well-formed typing: plain keys, shifted runs, prefixed arrows
    // with their releases, editing keys. The rest is ACKs and raw noise.
    while (bytes_sent < ItemTarget) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        press_key(7'($urandom_range(0, KeyTopTyped)));
      end else if (pick < 50) begin
        put_byte({1'b0, CodeLshift});
        n = $urandom_range(1, 4);
        repeat (n) press_key(7'($urandom_range(0, KeyTopTyped)));
        if ($urandom_range(0, 2) == 0) put_byte(CodePrefix);
        put_byte({1'b1, CodeLshift});
      end else if (pick < 70) begin
        case ($urandom_range(0, 3))
          0: arrow = CodeLeft;
          1: arrow = CodeUp;
          2: arrow = CodeRight;
          default: arrow = CodeDown;
        endcase
        put_byte(CodePrefix);
        put_byte({1'b0, arrow});
        if ($urandom_range(0, 1) == 1) begin
          put_byte(CodePrefix);
          put_byte({1'b1, arrow});
        end
      end else if (pick < 78) begin
        press_key(($urandom_range(0, 1) == 1) ? CodeBackspace : CodeEnter);
      end else if (pick < 84) begin
        put_byte(CodeAck);
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) put_byte(8'($urandom));
      end
      // Midway, let the pipe run completely dry once.
      if (!paused && bytes_sent >= ItemTarget / 2) begin
        hold_until_drained();
        paused = 1'b1;
      end
    end

    hold_until_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d scan bytes (ACKs aside) and %0d decoded keys,", bytes_sent,
             keys_checked);
    $display("mixing shift, E0 arrows, releases and noise under random gaps and stalls.");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
